[hw/rtl/pbla_pkg.sv]
// ----------------------------------------------------------------------------
// pbla_pkg
// Types and constants shared by the priority budget load admission block.
// ----------------------------------------------------------------------------
package pbla_pkg;

    localparam int CONS_W   = 16;
    localparam int BUDGET_W = 24;
    localparam int PRIO_W   = 2;
    localparam int RAW_W    = 3;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam logic [RAW_W-1:0]  PRIO_MIN     = 3'd1;
    localparam logic [RAW_W-1:0]  PRIO_MAX     = 3'd3;
    localparam logic [PRIO_W-1:0] PRIO_DEFAULT = 2'd2;

    // Value of the top address bit that selects the budget register.
    localparam logic REG_BUDGET = 1'b0;

    typedef struct packed {
        logic [CONS_W-1:0] consumption;
        logic [RAW_W-1:0]  priority_raw;
        logic              last_device;
    } t_item;

    typedef struct packed {
        logic [3:0]          device_index;
        logic [PRIO_W-1:0]   priority_res;
        logic [CONS_W-1:0]   consumption_out;
        logic                powered_on;
        logic [BUDGET_W-1:0] total_used;
        logic [BUDGET_W-1:0] remaining;
        logic                last_result;
    } t_result;

    // Classified request as held in the queue.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [CONS_W-1:0] cons;
        logic              last;
    } t_dev_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hw/rtl/priority_budget_load_admission_top.sv]
// ----------------------------------------------------------------------------
// priority_budget_load_admission_top
// Greedy priority load shedding: collects device records, then admits them
// in priority and consumption order against a programmable energy budget.
// ----------------------------------------------------------------------------
// Flow: requests are taken while the queue is not full; after the last request
// the back part emits the results one at a time, each after a full scan of the
// device store, whose single read port sets the pace of a run. The store is
// scanned once for every result.
// Reset: synchronous, active low; clears control state and the budget to 0.
// The device store is not cleared. Results cannot be stalled by the receiver.
module priority_budget_load_admission_top #(
    parameter int MAX_DEVICES      = 16,
    parameter int CONSUMPTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pbla_pkg::t_item               i_item,
    output logic                          o_strobe,
    output pbla_pkg::t_result             o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbla_pkg::ADDR_W-1:0]   paddr,
    input  logic [pbla_pkg::DATA_W-1:0]   pwdata,
    output logic [pbla_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [pbla_pkg::BUDGET_W-1:0] r_budget;
    logic                          cfg_wr;
    logic                          push;
    logic                          pop;
    pbla_pkg::t_dev_rec            front_rec;
    pbla_pkg::t_dev_rec            q_rec;
    pbla_pkg::t_q_status           q_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[pbla_pkg::ADDR_W-1] == pbla_pkg::REG_BUDGET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= '0;
        end else if (cfg_wr) begin
            r_budget <= pwdata[pbla_pkg::BUDGET_W-1:0];
        end
    end

    always_comb begin
        if (paddr[pbla_pkg::ADDR_W-1] == pbla_pkg::REG_BUDGET) begin
            prdata = pbla_pkg::DATA_W'(r_budget);
        end else begin
            prdata = '0;
        end
    end

    pbla_front u_front (
        .start      (start),
        .i_item     (i_item),
        .i_q_status (q_status),
        .busy       (busy),
        .o_push     (push),
        .o_rec      (front_rec)
    );

    pbla_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (front_rec),
        .i_pop    (pop),
        .o_rec    (q_rec),
        .o_status (q_status)
    );

    pbla_back #(
        .MAX_DEVICES      (MAX_DEVICES),
        .CONSUMPTION_BITS (CONSUMPTION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_budget   (r_budget),
        .i_rec      (q_rec),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

[hw/rtl/pbla_front.sv]
// ----------------------------------------------------------------------------
// pbla_front
// Accepts requests and classifies them, replacing an invalid priority.
// ----------------------------------------------------------------------------
module pbla_front (
    input  logic                start,
    input  pbla_pkg::t_item     i_item,
    input  pbla_pkg::t_q_status i_q_status,
    output logic                busy,
    output logic                o_push,
    output pbla_pkg::t_dev_rec  o_rec
);

    logic                        prio_ok;

    assign busy    = i_q_status.full;
    assign o_push  = start && !i_q_status.full;
    assign prio_ok = (i_item.priority_raw >= pbla_pkg::PRIO_MIN)
                  && (i_item.priority_raw <= pbla_pkg::PRIO_MAX);

    always_comb begin
        o_rec.cons = i_item.consumption;
        o_rec.last = i_item.last_device;
        if (prio_ok) begin
            o_rec.prio = i_item.priority_raw[pbla_pkg::PRIO_W-1:0];
        end else begin
            o_rec.prio = pbla_pkg::PRIO_DEFAULT;
        end
    end

endmodule

[hw/rtl/pbla_queue.sv]
// ----------------------------------------------------------------------------
// pbla_queue
// Two-entry queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module pbla_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pbla_pkg::t_dev_rec  i_rec,
    input  logic                i_pop,
    output pbla_pkg::t_dev_rec  o_rec,
    output pbla_pkg::t_q_status o_status
);

    pbla_pkg::t_dev_rec r_entry [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_fill;

    assign o_rec           = r_entry[r_rd_ptr];
    assign o_status.full   = r_fill[1];
    assign o_status.empty  = (r_fill == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_rec;
        end
    end

endmodule

[hw/rtl/pbla_back.sv]
// ----------------------------------------------------------------------------
// pbla_back
// Stores device records and, on the last one, emits them in priority and
// consumption order with greedy admission against the budget.
// ----------------------------------------------------------------------------
module pbla_back #(
    parameter int MAX_DEVICES      = 16,
    parameter int CONSUMPTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [pbla_pkg::BUDGET_W-1:0]       i_budget,
    input  pbla_pkg::t_dev_rec                  i_rec,
    input  pbla_pkg::t_q_status                 i_q_status,
    output logic                                o_pop,
    output logic                                o_strobe,
    output pbla_pkg::t_result                   o_result
);

    localparam int CW    = (CONSUMPTION_BITS < pbla_pkg::CONS_W) ?
                           CONSUMPTION_BITS : pbla_pkg::CONS_W;
    localparam int IW    = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CNTW  = $clog2(MAX_DEVICES + 1);
    localparam int ENT_W = pbla_pkg::PRIO_W + CW;
    localparam int KEY_W = ENT_W + IW;
    localparam int SUM_W = pbla_pkg::BUDGET_W + 1;

    localparam logic S_LOAD = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic [ENT_W-1:0]              r_mem [MAX_DEVICES];
    logic [ENT_W-1:0]              r_rd_data;
    logic                          r_state;
    logic [CNTW-1:0]               r_count;
    logic [CNTW-1:0]               r_n;
    logic [CNTW-1:0]               r_addr;
    logic [CNTW-1:0]               r_emitted;
    logic                          r_rd_vld;
    logic [IW-1:0]                 r_rd_idx;
    logic                          r_first;
    logic                          r_best_vld;
    logic [KEY_W-1:0]              r_best_key;
    logic [KEY_W-1:0]              r_prev_key;
    logic [pbla_pkg::BUDGET_W-1:0] r_total;
    logic                          r_strobe;
    pbla_pkg::t_result             r_res;

    logic                          store;
    logic [CNTW-1:0]               count_after;
    logic [KEY_W-1:0]              cand_key;
    logic                          better;
    logic                          scan_done;
    logic                          run_end;
    logic [CNTW-1:0]               emitted_inc;
    logic [pbla_pkg::PRIO_W-1:0]   best_prio;
    logic [CW-1:0]                 best_cons;
    logic [IW-1:0]                 best_idx;
    logic [SUM_W-1:0]              sum;
    logic                          fits;
    logic [pbla_pkg::BUDGET_W-1:0] n_total;

    assign o_pop       = (r_state == S_LOAD) && !i_q_status.empty;
    assign store       = o_pop && (r_count < CNTW'(MAX_DEVICES));
    assign count_after = store ? r_count + 1'b1 : r_count;

    // Keys are unique because the load position is the least significant
    // part, so each pass picks the smallest key above the previous result.
    assign cand_key  = {r_rd_data, r_rd_idx};
    assign better    = r_rd_vld && (r_first || (cand_key > r_prev_key))
                    && (!r_best_vld || (cand_key < r_best_key));
    assign scan_done = (r_addr == r_n) && !r_rd_vld;
    assign emitted_inc = r_emitted + 1'b1;
    assign run_end   = (emitted_inc == r_n);

    assign best_prio = r_best_key[KEY_W-1 -: pbla_pkg::PRIO_W];
    assign best_cons = r_best_key[IW +: CW];
    assign best_idx  = r_best_key[IW-1:0];

    assign sum     = {1'b0, r_total} + SUM_W'(best_cons);
    assign fits    = (sum <= {1'b0, i_budget});
    assign n_total = fits ? sum[pbla_pkg::BUDGET_W-1:0] : r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_n        <= '0;
            r_addr     <= '0;
            r_emitted  <= '0;
            r_rd_vld   <= 1'b0;
            r_first    <= 1'b1;
            r_best_vld <= 1'b0;
            r_total    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (o_pop) begin
                        r_count <= count_after;
                        if (i_rec.last) begin
                            r_state    <= S_SCAN;
                            r_n        <= count_after;
                            r_addr     <= '0;
                            r_rd_vld   <= 1'b0;
                            r_first    <= 1'b1;
                            r_best_vld <= 1'b0;
                            r_emitted  <= '0;
                            r_total    <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= (r_addr != r_n);
                    if (r_addr != r_n) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (better) begin
                        r_best_vld <= 1'b1;
                        r_best_key <= cand_key;
                    end
                    if (scan_done) begin
                        r_strobe   <= 1'b1;
                        r_total    <= n_total;
                        r_prev_key <= r_best_key;
                        r_first    <= 1'b0;
                        r_best_vld <= 1'b0;
                        r_addr     <= '0;
                        r_emitted  <= emitted_inc;
                        if (run_end) begin
                            r_state <= S_LOAD;
                            r_count <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_count[IW-1:0]] <= {i_rec.prio, i_rec.cons[CW-1:0]};
        end
        r_rd_data <= r_mem[r_addr[IW-1:0]];
        r_rd_idx  <= r_addr[IW-1:0];
        if ((r_state == S_SCAN) && scan_done) begin
            r_res.device_index    <= 4'(best_idx);
            r_res.priority_res    <= best_prio;
            r_res.consumption_out <= pbla_pkg::CONS_W'(best_cons);
            r_res.powered_on      <= fits;
            r_res.total_used      <= n_total;
            r_res.remaining       <= i_budget - n_total;
            r_res.last_result     <= run_end;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef SYNTH
    a_strobe_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_SCAN))
        else $error("result issued outside an evaluation run");

    a_total_within_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (SUM_W'(o_result.total_used) + SUM_W'(o_result.remaining)
                      == SUM_W'(i_budget)))
        else $error("admitted total exceeds the budget");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_DEVICES))
        else $error("device count beyond capacity");

    a_run_ends_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_result) |-> (r_state == S_LOAD && r_count == '0))
        else $error("run did not return to loading after its final result");
`endif

endmodule
